[design/lkt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key tracker package
// Shared sizes and the command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package lkt_pkg;

  localparam int DEPTH   = 16;
  localparam int KEY_W   = 64;
  localparam int LIM_W   = 5;
  localparam int OCC_W   = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

  typedef struct packed {
    logic load;
    logic cfg_write;
  } lkt_cmd_t;

endpackage

[design/lkt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key tracker controller
// Tracks whether the result register holds an untaken result and issues
// the load and configuration commands to the datapath.
// ----------------------------------------------------------------------------
module lkt_ctrl import lkt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output lkt_cmd_t cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready  = (state == ST_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_FULL);
  assign cfg_ready = 1'b1;

  assign cmd.load      = accept;
  assign cmd.cfg_write = cfg_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (accept) begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_ready && !accept) begin
          state_next = ST_EMPTY;
        end
      end
      default: begin
        state_next = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/lkt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key tracker datapath
// Recency-ordered key registers with parallel compare, shift to the front,
// eviction of the least recent key and the registered result.
// ----------------------------------------------------------------------------
module lkt_datapath import lkt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lkt_cmd_t         cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [LIM_W-1:0] cfg_data,
  output logic             hit,
  output logic             evicted,
  output logic [KEY_W-1:0] evicted_key,
  output logic [OCC_W-1:0] occupancy
);

  logic [KEY_W-1:0] keys [DEPTH];
  logic [KEY_W-1:0] keys_next [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [LIM_W-1:0] max_entries;

  logic [DEPTH-1:0] match;
  logic             is_hit;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] limit;
  logic             do_evict;
  logic [CNT_W-1:0] shift_n;
  logic [CNT_W-1:0] last;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count) && (keys[i] == key);
    end
    is_hit = |match;
    pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = CNT_W'(i);
      end
    end

    if ((max_entries == '0) || (32'(max_entries) > DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(max_entries);
    end

    do_evict = !is_hit && (count >= limit);
    last     = count - CNT_W'(1);

    if (is_hit) begin
      shift_n = pos;
    end else if (do_evict) begin
      shift_n = last;
    end else begin
      shift_n = count;
    end

    keys_next[0] = key;
    for (int i = 1; i < DEPTH; i++) begin
      keys_next[i] = (CNT_W'(i) <= shift_n) ? keys[i-1] : keys[i];
    end

    count_next = (!is_hit && !do_evict) ? count + CNT_W'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      max_entries <= LIMIT_RESET;
    end else begin
      if (cmd.cfg_write) begin
        max_entries <= cfg_data;
      end
      if (cmd.load) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        keys[i] <= keys_next[i];
      end
      hit         <= is_hit;
      evicted     <= do_evict;
      evicted_key <= do_evict ? keys[last[IDX_W-1:0]] : '0;
      occupancy   <= OCC_W'(count_next);
    end
  end

endmodule

[design/lru_key_tracker_with_eviction_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key tracker with eviction
// Keeps up to sixteen 64-bit keys in recency order and reports hits,
// evictions and occupancy for every touched key.
// ----------------------------------------------------------------------------
// Each request is handled in the cycle it is accepted and its result is
// held in an output register, so the block sustains one request per clock
// while the consumer keeps taking results; the rate rests on the combinational
// parallel compare and shift over the sixteen key registers. A new
// request is accepted whenever the result register is empty or its result
// is taken in the same cycle. The max_entries register resets to 16 and a
// value of 0 or above 16 selects the full store. The key store has no reset;
// only the entry count is cleared, so no clearing pass is needed.
module lru_key_tracker_with_eviction_core import lkt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             hit,
  output logic             evicted,
  output logic [KEY_W-1:0] evicted_key,
  output logic [OCC_W-1:0] occupancy,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data
);

  lkt_cmd_t cmd;

  lkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  lkt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key         (key),
    .cfg_data    (cfg_data),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .occupancy   (occupancy)
  );

endmodule
